>>> src/daf_pkg.sv
// Package for the duplicate-filtering admit FIFO.
// Holds shared widths, the default depth, result status codes and the control states.
// Depends on nothing.
package daf_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_DEQ   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DEQ
  } state_t;

endpackage

>>> src/dedup_admit_fifo.sv
// Duplicate-filtering admit FIFO: queue and seen list in two daf_ram instances; uses daf_pkg.
// Timing: the result strobe is registered and rises in the cycle after the deciding cycle. An add
//   to an empty seen list, a full rejection and an empty pop are decided in the accept cycle; a
//   dequeue in S_DEQ; a searching add in S_SEARCH, on a duplicate hit or at the last seen entry.
// Throughput: one request at a time; busy stays high through the seen-list scan or the pop read.
// Reset: synchronous rst_n empties the queue and the seen list; memory contents are not cleared.
module dedup_admit_fifo
  import daf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic signed [DATA_W-1:0]   in_item_value,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_data_out,
  output logic [COUNT_W-1:0]         out_queue_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [CW-1:0]     seen_cnt_r, seen_cnt_nxt;

  logic                valid_r;
  status_t             status_r;
  logic [DATA_W-1:0]   data_r;
  logic [COUNT_W-1:0]  count_r;

  logic [DATA_W-1:0] seen_rdata, q_rdata;
  logic [AW-1:0]     seen_raddr;
  logic [AW-1:0]     head_inc, tail_inc, last_idx;
  logic              accept, seen_full, hit;

  logic              do_add, do_deq, res_fire;
  status_t           res_status;
  logic [DATA_W-1:0] res_data, add_val;

  assign accept    = start && (state_r == S_IDLE);
  assign seen_full = (seen_cnt_r == CW'(DEPTH));
  assign hit       = (seen_rdata == val_r);
  assign last_idx  = AW'(seen_cnt_r - 1'b1);
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign add_val   = (state_r == S_IDLE) ? in_item_value : val_r;
  // Issue entry 0 while idle so the scan starts right after accept.
  assign seen_raddr = (state_r == S_SEARCH) ? idx_r + 1'b1 : '0;

  daf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_seen_ram (
    .clk     (clk),
    .wr_en   (do_add),
    .wr_addr (seen_cnt_r[AW-1:0]),
    .wr_data (add_val),
    .rd_addr (seen_raddr),
    .rd_data (seen_rdata)
  );

  daf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_queue_ram (
    .clk     (clk),
    .wr_en   (do_add),
    .wr_addr (tail_inc),
    .wr_data (add_val),
    .rd_addr (head_r),
    .rd_data (q_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            if (occ_r != '0) state_nxt = S_DEQ;
          end else if (!seen_full && seen_cnt_r != '0) begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit || idx_r == last_idx) state_nxt = S_IDLE;
      end
      S_DEQ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Actions and result of the current cycle
  always_comb begin
    do_add     = 1'b0;
    do_deq     = 1'b0;
    res_fire   = 1'b0;
    res_status = ST_ADDED;
    res_data   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            if (occ_r == '0) begin
              res_fire   = 1'b1;
              res_status = ST_EMPTY;
            end
          end else if (seen_full) begin
            res_fire   = 1'b1;
            res_status = ST_FULL;
          end else if (seen_cnt_r == '0) begin
            do_add     = 1'b1;
            res_fire   = 1'b1;
            res_status = ST_ADDED;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_fire   = 1'b1;
          res_status = ST_DUP;
        end else if (idx_r == last_idx) begin
          do_add     = 1'b1;
          res_fire   = 1'b1;
          res_status = ST_ADDED;
        end
      end
      S_DEQ: begin
        do_deq     = 1'b1;
        res_fire   = 1'b1;
        res_status = ST_DEQ;
        res_data   = q_rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    val_nxt      = accept ? in_item_value : val_r;
    idx_nxt      = (state_r == S_SEARCH) ? idx_r + 1'b1 : '0;
    head_nxt     = do_deq ? head_inc : head_r;
    tail_nxt     = do_add ? tail_inc : tail_r;
    seen_cnt_nxt = do_add ? seen_cnt_r + 1'b1 : seen_cnt_r;
    occ_nxt      = occ_r;
    if (do_add) occ_nxt = occ_r + 1'b1;
    if (do_deq) occ_nxt = occ_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= AW'(DEPTH - 1);
      occ_r      <= '0;
      seen_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      seen_cnt_r <= seen_cnt_nxt;
      valid_r    <= res_fire;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    if (res_fire) begin
      status_r <= res_status;
      data_r   <= res_data;
      count_r  <= COUNT_W'(occ_nxt);
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_queue_count = count_r;

  a_occ_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= seen_cnt_r)
    else $error("queue occupancy exceeds seen count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (CW'(idx_r) < seen_cnt_r))
    else $error("seen-list scan beyond filled entries");

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  a_added_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && res_status == ST_ADDED) |=> (seen_cnt_r == CW'($past(seen_cnt_r) + 1'b1)))
    else $error("added beat without seen-list growth");

endmodule

>>> src/daf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for both the queue store and the seen list. No dependencies.
module daf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> bench/admit_fifo_checker.sv
// Request codes for the bench, plus the checker that mirrors the admit FIFO's
// queue and seen list and compares every result beat; uses daf_pkg.
`timescale 1ns / 100ps

package daf_tb_pkg;
  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;
endpackage

module admit_fifo_checker
  import daf_pkg::*;
  import daf_tb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic                     out_valid,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic signed [DATA_W-1:0] out_data_out,
  input  logic [COUNT_W-1:0]       out_queue_count,
  output int                       fail_count,
  output int                       owed_n
);

  localparam int PW = $clog2(DEPTH);

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]         count;
  } fifo_result_t;

  logic [DATA_W-1:0] held [DEPTH];
  logic [DATA_W-1:0] admitted [DEPTH];
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  int                held_n;
  int                admitted_n;
  int                tally = 0;
  fifo_result_t      results_owed [$];

  // Apply one request to the mirrored state and return the result it must give.
  function automatic fifo_result_t admit_or_pop(input req_t kind, input logic [DATA_W-1:0] val);
    fifo_result_t r;
    logic         hit;
    r.status = ST_ADDED;
    r.data   = '0;
    hit      = 1'b0;
    if (kind == REQ_ADD) begin
      if (admitted_n >= DEPTH || held_n >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = 0; i < admitted_n; i++) begin
          if (admitted[i] == val) hit = 1'b1;
        end
        if (hit) begin
          r.status = ST_DUP;
        end else begin
          wr_ptr = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          held[wr_ptr] = val;
          held_n++;
          admitted[admitted_n] = val;
          admitted_n++;
        end
      end
    end else begin
      if (held_n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data   = held[rd_ptr];
        rd_ptr   = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        held_n--;
        r.status = ST_DEQ;
      end
    end
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    fifo_result_t due;
    if (!rst_n) begin
      rd_ptr     = '0;
      wr_ptr     = PW'(DEPTH - 1);
      held_n     = 0;
      admitted_n = 0;
      results_owed.delete();
    end else begin
      // Check the result beat before queuing the request taken at this edge.
      if (out_valid) begin
        if (results_owed.size() == 0) begin
          $display("%0t: result beat with nothing owed: status %0d data %h count %0d",
                   $time, out_status, out_data_out, out_queue_count);
          tally++;
        end else begin
          due = results_owed.pop_front();
          if (out_status !== due.status) begin
            $display("%0t: status expected %0d, got %0d", $time, due.status, out_status);
            tally++;
          end
          if (out_data_out !== due.data) begin
            $display("%0t: data_out expected %h, got %h", $time, due.data, out_data_out);
            tally++;
          end
          if (out_queue_count !== due.count) begin
            $display("%0t: queue_count expected %0d, got %0d",
                     $time, due.count, out_queue_count);
            tally++;
          end
        end
      end
      if (start && !busy) begin
        results_owed.push_back(admit_or_pop(req_t'(in_req_type), in_item_value));
      end
    end
    owed_n     <= results_owed.size();
    fail_count <= tally;
  end

endmodule

>>> bench/tb_top.sv
// Top of the admit FIFO bench: clock, reset, request stimulus and verdict.
// Depends on daf_pkg, dedup_admit_fifo and admit_fifo_checker (with daf_tb_pkg).
`timescale 1ns / 100ps

module tb_top
  import daf_pkg::*;
  import daf_tb_pkg::*;
;

  localparam int RAND_PER_PHASE = 267;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = DEPTH_DEF + 72;

  logic                     clk;
  logic                     rst_n         = 1'b0;
  logic                     start         = 1'b0;
  logic                     busy;
  logic                     in_req_type   = 1'b0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic [COUNT_W-1:0]       out_queue_count;
  int                       fail_count;
  int                       owed_n;
  int                       cycles = 0;
  logic [DATA_W-1:0]        offered [$];

  dedup_admit_fifo DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_queue_count (out_queue_count)
  );

  admit_fifo_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_queue_count (out_queue_count),
    .fail_count      (fail_count),
    .owed_n          (owed_n)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold start low for a random gap, then present one request until busy is low.
  task automatic issue(input req_t kind, input logic [DATA_W-1:0] val, input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= kind;
    in_item_value <= val;
    if (kind == REQ_ADD) offered.push_back(val);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int                idle_pct;
    int                add_pct;
    int unsigned       roll;
    req_t              kind;
    logic [DATA_W-1:0] val;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, extreme values, duplicates, re-add of a popped value.
    issue(REQ_DEQ, 32'h1234_5678, 0);
    issue(REQ_ADD, 32'h8000_0000, 0);
    issue(REQ_ADD, 32'h7FFF_FFFF, 0);
    issue(REQ_ADD, 32'h0000_0000, 0);
    issue(REQ_ADD, 32'hFFFF_FFFF, 0);
    issue(REQ_ADD, 32'h0000_0001, 0);
    issue(REQ_ADD, 32'hAAAA_AAAA, 0);
    issue(REQ_ADD, 32'h5555_5555, 0);
    issue(REQ_ADD, 32'h7FFF_FFFF, 0);
    issue(REQ_ADD, 32'h5555_5555, 0);
    issue(REQ_DEQ, 32'hFFFF_FFFF, 0);
    issue(REQ_ADD, 32'h8000_0000, 0);
    repeat (6) issue(REQ_DEQ, 32'h0000_0000, 0);
    issue(REQ_DEQ, 32'h0000_0000, 0);
    issue(REQ_ADD, 32'h0000_0000, 0);
    issue(REQ_ADD, 32'h0000_0002, 0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 26 : (ph == 1) ? 70 : 0;
      add_pct  = (ph == 0) ? 70 : (ph == 1) ? 55 : 45;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        kind = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_DEQ;
        roll = $urandom_range(99);
        // Mix repeats of earlier values with corner values and fresh words.
        if (roll < 35 && offered.size() > 0) begin
          val = offered[$urandom_range(offered.size() - 1)];
        end else if (roll < 50) begin
          case ($urandom_range(4))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom_range(15);
          endcase
        end else begin
          val = $urandom;
        end
        issue(kind, val, idle_pct);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (owed_n != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
